// ----- hw/rtl/velocity_sample_resampler_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the velocity sample resampler
// Clocked property wrappers used by the checker file vsr_checker.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_SAMPLE_RESAMPLER_ASSERT_SVH
`define VELOCITY_SAMPLE_RESAMPLER_ASSERT_SVH

// Check on every rising edge outside reset.
`define VSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define VSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/vsr_pkg.sv -----
// ----------------------------------------------------------------------------
// vsr_pkg
// Widths, codes and shared types of the velocity sample resampler.
// ----------------------------------------------------------------------------
package vsr_pkg;

  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned VEL_W     = 32;
  localparam int unsigned NUM_LANES = 6;
  localparam int unsigned PERIOD_W  = 24;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned MAG_W     = VEL_W + 1;
  localparam int unsigned PROD_W    = MAG_W + PERIOD_W;
  localparam int unsigned CNT_W     = $clog2(PROD_W);
  localparam int unsigned DATA_BITS = TIME_BITS + NUM_LANES * VEL_W;
  localparam int unsigned TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10000);

  typedef enum logic [STATUS_W-1:0] {
    ST_INTERP    = 3'd0,
    ST_FIRST     = 3'd1,
    ST_INVALID   = 3'd2,
    ST_NOT_NEWER = 3'd3,
    ST_TOO_SOON  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
  } lane_cmd_t;

  typedef struct packed {
    logic    emit;
    status_e status;
  } emit_t;

endpackage

// ----- hw/rtl/vsr_lane.sv -----
// ----------------------------------------------------------------------------
// vsr_lane
// One velocity component: difference, scale by period, bit-serial divide
// by the time step, and add back to the old value.
// ----------------------------------------------------------------------------
module vsr_lane (
  input  logic                              clk_i,
  input  vsr_pkg::lane_cmd_t                cmd_i,
  input  logic [vsr_pkg::VEL_W-1:0]         old_vel_i,
  input  logic [vsr_pkg::VEL_W-1:0]         new_vel_i,
  input  logic [vsr_pkg::PERIOD_W-1:0]      period_i,
  input  logic [vsr_pkg::TIME_BITS-1:0]     dt_i,
  output logic [vsr_pkg::VEL_W-1:0]         result_o
);

  logic [vsr_pkg::MAG_W-1:0]     diff;
  logic                          neg;
  logic [vsr_pkg::MAG_W-1:0]     mag;
  logic [vsr_pkg::PROD_W-1:0]    prod;
  logic [vsr_pkg::TIME_BITS:0]   rem_sh;
  logic [vsr_pkg::TIME_BITS:0]   rem_sub;
  logic                          fits;
  logic [vsr_pkg::VEL_W+1:0]     old_ext;
  logic [vsr_pkg::VEL_W+1:0]     q_ext;
  logic [vsr_pkg::VEL_W+1:0]     sum;

  logic                          neg_q;
  logic [vsr_pkg::MAG_W-1:0]     mag_q;
  logic [vsr_pkg::PROD_W-1:0]    quo_q;
  logic [vsr_pkg::TIME_BITS-1:0] rem_q;

  assign diff = {new_vel_i[vsr_pkg::VEL_W-1], new_vel_i}
              - {old_vel_i[vsr_pkg::VEL_W-1], old_vel_i};
  assign neg  = diff[vsr_pkg::MAG_W-1];
  assign mag  = neg ? (~diff + vsr_pkg::MAG_W'(1)) : diff;
  assign prod = vsr_pkg::PROD_W'(mag_q) * vsr_pkg::PROD_W'(period_i);

  // Restoring division step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh  = {rem_q, quo_q[vsr_pkg::PROD_W-1]};
  assign fits    = rem_sh >= {1'b0, dt_i};
  assign rem_sub = rem_sh - {1'b0, dt_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= neg;
      mag_q <= mag;
    end
    if (cmd_i.mul) begin
      quo_q <= prod;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      rem_q <= fits ? rem_sub[vsr_pkg::TIME_BITS-1:0] : rem_sh[vsr_pkg::TIME_BITS-1:0];
      quo_q <= {quo_q[vsr_pkg::PROD_W-2:0], fits};
    end
  end

  // Quotient never exceeds the magnitude, so its low bits carry it all.
  assign old_ext  = {{2{old_vel_i[vsr_pkg::VEL_W-1]}}, old_vel_i};
  assign q_ext    = {1'b0, quo_q[vsr_pkg::MAG_W-1:0]};
  assign sum      = neg_q ? (old_ext - q_ext) : (old_ext + q_ext);
  assign result_o = sum[vsr_pkg::VEL_W-1:0];

endmodule

// ----- hw/rtl/vsr_ctrl.sv -----
// ----------------------------------------------------------------------------
// vsr_ctrl
// Sample checks and sequencing of the lanes through load, scale and divide.
// ----------------------------------------------------------------------------
module vsr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [vsr_pkg::TIME_BITS-1:0] sample_time_i,
  input  logic                          invalid_i,
  input  logic [vsr_pkg::TIME_BITS-1:0] ref_time_i,
  input  logic                          have_ref_i,
  input  logic [vsr_pkg::PERIOD_W-1:0]  period_i,
  input  logic                          out_free_i,
  output logic                          in_ready_o,
  output vsr_pkg::lane_cmd_t            cmd_o,
  output logic [vsr_pkg::TIME_BITS-1:0] dt_o,
  output vsr_pkg::emit_t                emit_o
);

  vsr_pkg::ctrl_state_e state_q, state_d;
  vsr_pkg::status_e     status_q, status_d, status_c;
  logic [vsr_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [vsr_pkg::TIME_BITS-1:0] dt_q, dt_d;
  logic [vsr_pkg::TIME_BITS:0]   delta;
  logic                          newer;
  logic                          too_soon;

  // Borrow of the subtraction, with a non-zero difference, tells whether the sample is newer.
  assign delta    = {1'b0, sample_time_i} - {1'b0, ref_time_i};
  assign newer    = !delta[vsr_pkg::TIME_BITS] && (delta[vsr_pkg::TIME_BITS-1:0] != '0);
  assign too_soon = delta[vsr_pkg::TIME_BITS-1:0] < vsr_pkg::TIME_BITS'(period_i);

  always_comb begin
    if (invalid_i) begin
      status_c = vsr_pkg::ST_INVALID;
    end else if (!newer) begin
      status_c = vsr_pkg::ST_NOT_NEWER;
    end else if (too_soon) begin
      status_c = vsr_pkg::ST_TOO_SOON;
    end else if (!have_ref_i) begin
      status_c = vsr_pkg::ST_FIRST;
    end else begin
      status_c = vsr_pkg::ST_INTERP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vsr_pkg::S_IDLE;
      status_q <= vsr_pkg::ST_INTERP;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q <= dt_d;
  end

  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    cnt_d         = cnt_q;
    dt_d          = dt_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    emit_o.emit   = 1'b0;
    emit_o.status = status_q;
    case (state_q)
      vsr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = vsr_pkg::S_EVAL;
        end
      end
      vsr_pkg::S_EVAL: begin
        cmd_o.load = 1'b1;
        status_d   = status_c;
        dt_d       = delta[vsr_pkg::TIME_BITS-1:0];
        state_d    = (status_c == vsr_pkg::ST_INTERP) ? vsr_pkg::S_MUL : vsr_pkg::S_EMIT;
      end
      vsr_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = vsr_pkg::S_DIV;
      end
      vsr_pkg::S_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + vsr_pkg::CNT_W'(1);
        if (cnt_q == vsr_pkg::CNT_W'(vsr_pkg::PROD_W - 1)) begin
          state_d = vsr_pkg::S_EMIT;
        end
      end
      vsr_pkg::S_EMIT: begin
        if (out_free_i) begin
          emit_o.emit = 1'b1;
          state_d     = vsr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = vsr_pkg::S_IDLE;
      end
    endcase
  end

  assign dt_o = dt_q;

endmodule

// ----- hw/rtl/velocity_sample_resampler.sv -----
// ----------------------------------------------------------------------------
// velocity_sample_resampler
// Sequence: a taken request is checked in S_EVAL; a rejected or first sample
//   goes straight to S_EMIT, an interpolated one first passes S_MUL and the
//   57-step divider in each lane (S_DIV). The result is registered once S_EMIT
//   finds the output free; a stalled result delays the register. The next
//   request is taken only after the result is registered, one at a time.
// Reset: asynchronous, active low; clears the reference point, period 10000 us.
// ----------------------------------------------------------------------------
module velocity_sample_resampler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: output period in microseconds
  input  logic                                cfg_wr_en_i,
  input  logic [vsr_pkg::PERIOD_W-1:0]        cfg_wr_data_i,
  // Sample requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low bit up: sample_time, lin_vel_x, lin_vel_y, lin_vel_z,
  //   ang_vel_x, ang_vel_y, ang_vel_z
  input  logic [vsr_pkg::TDATA_W-1:0]         s_axis_tdata,
  // tuser: sample_invalid
  input  logic                                s_axis_tuser,
  // Resampled points
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low bit up: out_time, out_lin_x, out_lin_y, out_lin_z,
  //   out_ang_x, out_ang_y, out_ang_z
  output logic [vsr_pkg::TDATA_W-1:0]         m_axis_tdata,
  // tuser: status
  output logic [vsr_pkg::STATUS_W-1:0]        m_axis_tuser
);

  localparam int unsigned TB = vsr_pkg::TIME_BITS;
  localparam int unsigned VW = vsr_pkg::VEL_W;
  localparam int unsigned NL = vsr_pkg::NUM_LANES;

  // Configuration and reference point
  logic [vsr_pkg::PERIOD_W-1:0] period_q;
  logic [TB-1:0]                ref_time_q;
  logic [VW-1:0]                ref_vel_q [NL];
  logic                         have_ref_q;

  // Taken request
  logic [TB-1:0]                in_time_q;
  logic [VW-1:0]                in_vel_q [NL];
  logic                         in_inv_q;

  // Output register
  logic                         m_valid_q;
  vsr_pkg::status_e             m_status_q;
  logic [TB-1:0]                m_time_q;
  logic [VW-1:0]                m_vel_q [NL];

  logic                         in_fire;
  logic                         out_free;
  logic [TB-1:0]                next_time;
  logic [VW-1:0]                lane_res [NL];
  vsr_pkg::lane_cmd_t           lane_cmd;
  logic [TB-1:0]                dt;
  vsr_pkg::emit_t               emit;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign next_time = ref_time_q + TB'(period_q);

  // Hold the request while the lanes work on it.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_time_q <= s_axis_tdata[TB-1:0];
      in_inv_q  <= s_axis_tuser;
      for (int i = 0; i < NL; i++) begin
        in_vel_q[i] <= s_axis_tdata[TB + i*VW +: VW];
      end
    end
  end

  vsr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .sample_time_i (in_time_q),
    .invalid_i     (in_inv_q),
    .ref_time_i    (ref_time_q),
    .have_ref_i    (have_ref_q),
    .period_i      (period_q),
    .out_free_i    (out_free),
    .in_ready_o    (s_axis_tready),
    .cmd_o         (lane_cmd),
    .dt_o          (dt),
    .emit_o        (emit)
  );

  // One lane per velocity component, all stepping together.
  for (genvar g = 0; g < NL; g++) begin : g_lane
    vsr_lane u_lane (
      .clk_i     (clk_i),
      .cmd_i     (lane_cmd),
      .old_vel_i (ref_vel_q[g]),
      .new_vel_i (in_vel_q[g]),
      .period_i  (period_q),
      .dt_i      (dt),
      .result_o  (lane_res[g])
    );
  end

  // Merge: advance the reference point on a kept sample; a rejected one
  // leaves it alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= vsr_pkg::PERIOD_RESET;
      ref_time_q <= '0;
      have_ref_q <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        ref_vel_q[i] <= '0;
      end
    end else begin
      if (cfg_wr_en_i) begin
        period_q <= cfg_wr_data_i;
      end
      if (emit.emit) begin
        case (emit.status)
          vsr_pkg::ST_INTERP: begin
            ref_time_q <= next_time;
            for (int i = 0; i < NL; i++) begin
              ref_vel_q[i] <= lane_res[i];
            end
          end
          vsr_pkg::ST_FIRST: begin
            ref_time_q <= in_time_q;
            have_ref_q <= 1'b1;
            for (int i = 0; i < NL; i++) begin
              ref_vel_q[i] <= in_vel_q[i];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output valid: set on emit, drop once the point is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output payload; a rejected sample reports zeros.
  always_ff @(posedge clk_i) begin
    if (emit.emit) begin
      m_status_q <= emit.status;
      case (emit.status)
        vsr_pkg::ST_INTERP: begin
          m_time_q <= next_time;
          for (int i = 0; i < NL; i++) begin
            m_vel_q[i] <= lane_res[i];
          end
        end
        vsr_pkg::ST_FIRST: begin
          m_time_q <= in_time_q;
          for (int i = 0; i < NL; i++) begin
            m_vel_q[i] <= in_vel_q[i];
          end
        end
        default: begin
          m_time_q <= '0;
          for (int i = 0; i < NL; i++) begin
            m_vel_q[i] <= '0;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;

  always_comb begin
    m_axis_tdata       = '0;
    m_axis_tdata[TB-1:0] = m_time_q;
    for (int i = 0; i < NL; i++) begin
      m_axis_tdata[TB + i*VW +: VW] = m_vel_q[i];
    end
  end

endmodule

// ----- hw/rtl/vsr_checker.sv -----
// ----------------------------------------------------------------------------
// vsr_checker
// Port-level checks of the velocity sample resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "velocity_sample_resampler_assert.svh"

module vsr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [vsr_pkg::TDATA_W-1:0]   m_axis_tdata,
  input  logic [vsr_pkg::STATUS_W-1:0]  m_axis_tuser
);

  logic rejected;

  assign rejected = m_axis_tuser inside {vsr_pkg::ST_INVALID, vsr_pkg::ST_NOT_NEWER,
                                         vsr_pkg::ST_TOO_SOON};

  // A rejected sample carries no time and no velocities.
  `VSR_ASSERT(a_reject_zero, m_axis_tvalid && rejected |-> m_axis_tdata == '0, "rejected sample with non-zero payload")

  // One request at a time: ready drops after a request is taken.
  `VSR_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")

  // A stalled result holds.
  `VSR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // Reset clears any result by the following edge.
  `VSR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "result valid in reset")

endmodule

bind velocity_sample_resampler vsr_checker u_vsr_checker (.*);
